### src/gbe_pkg.sv
// Shared constants, register indexes and the lane batch type of the glyph expander.
package gbe_pkg;

  localparam int LANES      = 8;
  localparam int LANE_IDX_W = $clog2(LANES);
  localparam int CFG_W      = 6;
  localparam int CODE_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int ADDR_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE   = 2'd2;

  localparam logic [CFG_W-1:0]  GLYPH_WIDTH_RST  = 6'd8;
  localparam logic [CFG_W-1:0]  GLYPH_HEIGHT_RST = 6'd16;
  localparam logic [CODE_W-1:0] FIRST_CODE_RST   = 8'd32;

  // Everything about one byte that does not depend on the coordinate width.
  // Bits and mask are in lane order: lane 0 is the leftmost pixel.
  typedef struct packed {
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [ADDR_W-1:0]  addr;
    logic [LANES-1:0]   bits;
    logic [LANES-1:0]   mask;
  } gbe_batch_t;

endpackage

### src/gbe_in_if.sv
// Glyph byte request channel.
interface gbe_in_if import gbe_pkg::*; #(parameter int CW = 12) ();
  logic              valid;
  logic              ready;
  logic              first_of_glyph;
  logic [CW-1:0]     origin_y;
  logic [CW-1:0]     origin_x;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic [CODE_W-1:0] glyph_code;
  logic [7:0]        font_byte;

  modport source (output valid, first_of_glyph, origin_y, origin_x, fg_color, bg_color,
                  glyph_code, font_byte, input ready);
  modport sink   (input valid, first_of_glyph, origin_y, origin_x, fg_color, bg_color,
                  glyph_code, font_byte, output ready);
endinterface

### src/gbe_out_if.sv
// Pixel write request channel.
interface gbe_out_if import gbe_pkg::*; #(parameter int CW = 12) ();
  logic               valid;
  logic               ready;
  logic [CW-1:0]      pixel_y;
  logic [CW-1:0]      pixel_x;
  logic [COLOR_W-1:0] pixel_color;
  logic [ADDR_W-1:0]  font_addr;
  logic               last;

  modport source (output valid, pixel_y, pixel_x, pixel_color, font_addr, last, input ready);
  modport sink   (input valid, pixel_y, pixel_x, pixel_color, font_addr, last, output ready);
endinterface

### src/gbe_cfg_if.sv
// Configuration register write channel.
interface gbe_cfg_if import gbe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

### src/gbe_lane.sv
// One pixel lane: decides whether its bit lies inside the row and whether it writes.
module gbe_lane import gbe_pkg::*; #(
  parameter int LANE = 0
) (
  input  logic [CFG_W-1:0] column_count,
  input  logic [CFG_W-1:0] width,
  input  logic             pixel_bit,
  input  logic             bg_opaque,
  output logic             emit,
  output logic             stop
);

  logic [CFG_W:0] col;
  logic           active;

  assign col = {1'b0, column_count} + (CFG_W+1)'(LANE);

  // A lane is reached only if every lane to its left stayed inside the row.
  assign active = (LANE == 0) || (col < {1'b0, width});
  assign stop   = active && ((col + 1'b1) >= {1'b0, width});
  assign emit   = active && (pixel_bit || bg_opaque);

endmodule

### src/gbe_merge.sv
// Merging stage: holds lane results; sends written pixels one per unstalled cycle.
module gbe_merge import gbe_pkg::*; #(
  parameter int CW = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  gbe_batch_t  batch,
  input  logic [CW-1:0] row,
  input  logic [CW-1:0] base_x,
  output logic        ready,
  gbe_out_if.source   pixel
);

  logic              hold_valid;
  gbe_batch_t        hold;
  logic [CW-1:0]     hold_y;
  logic [CW-1:0]     hold_x;

  gbe_batch_t        ser;
  logic [CW-1:0]     ser_y;
  logic [CW-1:0]     ser_x;

  logic                  ser_busy;
  logic                  single;
  logic                  fire;
  logic                  load_ser;
  logic [LANE_IDX_W-1:0] idx;

  assign ser_busy = |ser.mask;
  assign single   = ((ser.mask & (ser.mask - 1'b1)) == '0);
  assign fire     = pixel.valid && pixel.ready;
  assign load_ser = hold_valid && (!ser_busy || (fire && single));
  // The hold slot takes a new byte in the cycle that it hands its own one on.
  assign ready    = !hold_valid || load_ser;

  always_comb begin
    idx = '0;
    for (int k = LANES - 1; k >= 0; k--) begin
      if (ser.mask[k]) begin
        idx = LANE_IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= 1'b1;
    end else if (load_ser) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold   <= batch;
      hold_y <= row;
      hold_x <= base_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser.mask <= '0;
    end else if (load_ser) begin
      ser.mask <= hold.mask;
    end else if (fire) begin
      ser.mask <= ser.mask & (ser.mask - 1'b1);
    end
    if (load_ser) begin
      ser.fg   <= hold.fg;
      ser.bg   <= hold.bg;
      ser.addr <= hold.addr;
      ser.bits <= hold.bits;
      ser_y    <= hold_y;
      ser_x    <= hold_x;
    end
  end

  assign pixel.valid       = ser_busy;
  assign pixel.pixel_y     = ser_y;
  assign pixel.pixel_x     = ser_x + CW'(idx);
  assign pixel.pixel_color = ser.bits[idx] ? ser.fg : ser.bg;
  assign pixel.font_addr   = ser.addr;
  assign pixel.last        = single;

endmodule

### src/glyph_bitmap_expander.sv
// Top level of the glyph expander: registers, glyph state, eight lanes and the merging stage.
//
//   channel  direction  carries
//   glyph    sink       one font byte, plus origin, colours and code on a glyph's first byte
//   pixel    source     one pixel write: y, x, colour, font address, last of byte
//   cfg      sink       register write: index, data (always ready)
//
// The pixel port sends one write a cycle while pixel ready is high. A byte is taken by all
// eight lanes together and waits in a hold slot while the previous byte drains, so bytes
// follow one another without gaps on the pixel port. Bytes that write nothing are absorbed
// at one a cycle while glyph ready is high. Reset restores register defaults and clears
// the glyph state. A stalled pixel port fills the hold slot, after which glyph ready drops.
module glyph_bitmap_expander import gbe_pkg::*; #(
  parameter int MAX_GLYPH_WIDTH = 32,
  parameter int COORD_BITS      = 12
) (
  input  logic      clk,
  input  logic      rst,
  gbe_in_if.sink    glyph,
  gbe_out_if.source pixel,
  gbe_cfg_if.sink   cfg
);

  localparam logic [CFG_W:0] MAX_W = (CFG_W+1)'(MAX_GLYPH_WIDTH);

  logic [CFG_W-1:0]  glyph_width;
  logic [CFG_W-1:0]  glyph_height;
  logic [CODE_W-1:0] first_code;

  logic [COORD_BITS-1:0] row_y;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] start_x;
  logic [CFG_W-1:0]      column_count;
  logic [ADDR_W-1:0]     byte_address;
  logic [COLOR_W-1:0]    fg_latched;
  logic [COLOR_W-1:0]    bg_latched;

  logic [CFG_W-1:0]      width;
  logic [3:0]            bytes_per_row;
  logic [9:0]            per_glyph;
  logic [CODE_W-1:0]     code_off;
  logic [17:0]           glyph_base;

  logic [COORD_BITS-1:0] y0;
  logic [COORD_BITS-1:0] sx0;
  logic [COORD_BITS-1:0] cx0;
  logic [CFG_W-1:0]      cc0;
  logic [ADDR_W-1:0]     addr0;
  logic [COLOR_W-1:0]    fg0;
  logic [COLOR_W-1:0]    bg0;

  logic [LANES-1:0]      lane_bits;
  logic [LANES-1:0]      lane_emit;
  logic [LANES-1:0]      lane_stop;
  logic                  row_break;
  logic                  accept;
  logic                  merge_ready;
  gbe_batch_t            batch;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= GLYPH_WIDTH_RST;
      glyph_height <= GLYPH_HEIGHT_RST;
      first_code   <= FIRST_CODE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_GLYPH_WIDTH:  glyph_width  <= cfg.data[CFG_W-1:0];
        REG_GLYPH_HEIGHT: glyph_height <= cfg.data[CFG_W-1:0];
        REG_FIRST_CODE:   first_code   <= cfg.data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // A width of zero behaves as one; widths past the cell limit are clipped.
  always_comb begin
    if (glyph_width == '0) begin
      width = CFG_W'(1);
    end else if ({1'b0, glyph_width} > MAX_W) begin
      width = MAX_W[CFG_W-1:0];
    end else begin
      width = glyph_width;
    end
  end

  assign bytes_per_row = 4'(({1'b0, width} + 7'd7) >> 3);
  assign per_glyph     = 10'(bytes_per_row) * 10'(glyph_height);
  assign code_off      = glyph.glyph_code - first_code;
  assign glyph_base    = 18'(code_off) * 18'(per_glyph);

  // On a glyph's first byte the lanes see the origin, colours and address of the request itself.
  always_comb begin
    if (glyph.first_of_glyph) begin
      y0    = glyph.origin_y;
      sx0   = glyph.origin_x;
      cx0   = glyph.origin_x;
      cc0   = '0;
      addr0 = glyph_base[ADDR_W-1:0];
      fg0   = glyph.fg_color;
      bg0   = glyph.bg_color;
    end else begin
      y0    = row_y;
      sx0   = start_x;
      cx0   = cur_x;
      cc0   = column_count;
      addr0 = byte_address;
      fg0   = fg_latched;
      bg0   = bg_latched;
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    assign lane_bits[j] = glyph.font_byte[LANES-1-j];
    gbe_lane #(.LANE(j)) u_lane (
      .column_count (cc0),
      .width        (width),
      .pixel_bit    (lane_bits[j]),
      .bg_opaque    (bg0 != '0),
      .emit         (lane_emit[j]),
      .stop         (lane_stop[j])
    );
  end

  assign row_break   = |lane_stop;
  assign glyph.ready = merge_ready;
  assign accept      = glyph.valid && merge_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_y        <= '0;
      cur_x        <= '0;
      start_x      <= '0;
      column_count <= '0;
      byte_address <= '0;
      fg_latched   <= '0;
      bg_latched   <= '0;
    end else if (accept) begin
      start_x      <= sx0;
      fg_latched   <= fg0;
      bg_latched   <= bg0;
      byte_address <= addr0 + 1'b1;
      if (row_break) begin
        row_y        <= y0 + 1'b1;
        cur_x        <= sx0;
        column_count <= '0;
      end else begin
        row_y        <= y0;
        cur_x        <= cx0 + COORD_BITS'(LANES);
        column_count <= cc0 + CFG_W'(LANES);
      end
    end
  end

  assign batch.fg   = fg0;
  assign batch.bg   = bg0;
  assign batch.addr = addr0;
  assign batch.bits = lane_bits;
  assign batch.mask = lane_emit;

  gbe_merge #(.CW(COORD_BITS)) u_merge (
    .clk    (clk),
    .rst    (rst),
    .load   (accept && (lane_emit != '0)),
    .batch  (batch),
    .row    (y0),
    .base_x (cx0),
    .ready  (merge_ready),
    .pixel  (pixel)
  );

endmodule

### src/gbe_checker.sv
// Port-level checks of the glyph expander and their binding to the top level.
module gbe_checker #(
  parameter int CW = 12
) (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic          out_last,
  input logic [CW-1:0] out_x,
  input logic [15:0]   out_addr
);

  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel request dropped while stalled");

  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_addr) && $stable(out_last))
    else $error("pixel request changed while stalled");

  // A byte that is not finished must go on with its next pixel.
  a_byte_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("byte ended without a last pixel");

  // A full hold slot means pixels are on their way in the following cycle.
  a_hold_drains: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> out_valid)
    else $error("glyph channel blocked with no pixel pending");

endmodule

bind glyph_bitmap_expander gbe_checker #(.CW(COORD_BITS)) u_gbe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (glyph.ready),
  .out_valid (pixel.valid),
  .out_ready (pixel.ready),
  .out_last  (pixel.last),
  .out_x     (pixel.pixel_x),
  .out_addr  (pixel.font_addr)
);

### tb/glyph_bitmap_expander_tb.sv
// Self-checking testbench for the glyph bitmap expander: directed, back-pressure and random tests.
module glyph_bitmap_expander_tb import gbe_pkg::*; ();

  localparam int CW            = 12;
  localparam int MAX_W         = 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_ITEMS  = 280;

  typedef struct packed {
    logic               first;
    logic [CW-1:0]      oy;
    logic [CW-1:0]      ox;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [CODE_W-1:0]  code;
    logic [7:0]         fbyte;
  } glyph_req_t;

  typedef struct packed {
    logic [CW-1:0]      y;
    logic [CW-1:0]      x;
    logic [COLOR_W-1:0] color;
    logic [ADDR_W-1:0]  addr;
    logic               last;
  } pixel_req_t;

  logic clk;
  logic rst;

  gbe_in_if  #(.CW(CW)) glyph_ch ();
  gbe_out_if #(.CW(CW)) pixel_ch ();
  gbe_cfg_if            cfg_ch ();

  glyph_bitmap_expander #(
    .MAX_GLYPH_WIDTH(MAX_W),
    .COORD_BITS(CW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .glyph(glyph_ch),
    .pixel(pixel_ch),
    .cfg(cfg_ch)
  );

  pixel_req_t pending_pixels[$];
  int mismatches    = 0;
  int items_sent    = 0;
  int cycle_count   = 0;
  bit idle_on       = 1'b1;
  int hold_off_req  = 0;

  // Predicted copy of the registers and the glyph state.
  logic [5:0]         m_width;
  logic [5:0]         m_height;
  logic [CODE_W-1:0]  m_first_code;
  logic [CW-1:0]      m_row_y;
  logic [CW-1:0]      m_cur_x;
  logic [CW-1:0]      m_start_x;
  logic [5:0]         m_col;
  logic [ADDR_W-1:0]  m_addr;
  logic [COLOR_W-1:0] m_fg;
  logic [COLOR_W-1:0] m_bg;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int unsigned eff_width(input logic [5:0] w);
    if (w == 6'd0) return 1;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  // Works out the pixel writes of one accepted glyph byte and queues them.
  function automatic void expand_glyph_byte(input glyph_req_t r);
    int unsigned w;
    int unsigned per_glyph;
    int unsigned col;
    int n;
    int j;
    logic bit_v;
    logic [7:0] code_off;
    pixel_req_t batch[8];
    w = eff_width(m_width);
    n = 0;
    if (r.first) begin
      per_glyph = ((w + 7) >> 3) * m_height;
      code_off  = r.code - m_first_code;
      m_row_y   = r.oy;
      m_start_x = r.ox;
      m_cur_x   = r.ox;
      m_fg      = r.fg;
      m_bg      = r.bg;
      m_col     = '0;
      m_addr    = ADDR_W'(code_off * per_glyph);
    end
    for (j = 0; j < 8; j++) begin
      bit_v = r.fbyte[7-j];
      if (bit_v || m_bg != '0) begin
        batch[n].y     = m_row_y;
        batch[n].x     = m_cur_x;
        batch[n].color = bit_v ? m_fg : m_bg;
        batch[n].addr  = m_addr;
        batch[n].last  = 1'b0;
        n++;
      end
      m_cur_x = m_cur_x + 1'b1;
      col = m_col + 1;
      if (col >= w) begin
        // The row is complete: the rest of the byte is dropped.
        m_col   = '0;
        m_row_y = m_row_y + 1'b1;
        m_cur_x = m_start_x;
        break;
      end
      m_col = col[5:0];
    end
    if (n > 0) batch[n-1].last = 1'b1;
    for (j = 0; j < n; j++) pending_pixels.push_back(batch[j]);
    m_addr = m_addr + 1'b1;
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: pixel %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Prediction and checking share one process so that their order at an edge is fixed.
  always @(posedge clk) begin : pixel_monitor
    glyph_req_t seen;
    pixel_req_t want;
    if (rst) begin
      m_width      = GLYPH_WIDTH_RST;
      m_height     = GLYPH_HEIGHT_RST;
      m_first_code = FIRST_CODE_RST;
      m_row_y      = '0;
      m_cur_x      = '0;
      m_start_x    = '0;
      m_col        = '0;
      m_addr       = '0;
      m_fg         = '0;
      m_bg         = '0;
      pending_pixels.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_GLYPH_WIDTH:  m_width      = cfg_ch.data[5:0];
          REG_GLYPH_HEIGHT: m_height     = cfg_ch.data[5:0];
          REG_FIRST_CODE:   m_first_code = cfg_ch.data;
          default: ;
        endcase
      end
      if (glyph_ch.valid && glyph_ch.ready) begin
        seen.first = glyph_ch.first_of_glyph;
        seen.oy    = glyph_ch.origin_y;
        seen.ox    = glyph_ch.origin_x;
        seen.fg    = glyph_ch.fg_color;
        seen.bg    = glyph_ch.bg_color;
        seen.code  = glyph_ch.glyph_code;
        seen.fbyte = glyph_ch.font_byte;
        expand_glyph_byte(seen);
      end
      if (pixel_ch.valid && pixel_ch.ready) begin
        if (pending_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: pixel mismatch, expected none, actual y=%0h x=%0h color=%0h",
                   $time, pixel_ch.pixel_y, pixel_ch.pixel_x, pixel_ch.pixel_color);
        end else begin
          want = pending_pixels.pop_front();
          compare_field("y", want.y, pixel_ch.pixel_y);
          compare_field("x", want.x, pixel_ch.pixel_x);
          compare_field("color", want.color, pixel_ch.pixel_color);
          compare_field("addr", want.addr, pixel_ch.font_addr);
          compare_field("last", want.last, pixel_ch.last);
        end
      end
    end
  end

  // Pixel receiver: random stalls per request, plus a long hold-off when one is asked for.
  initial begin : pixel_receiver
    int gap;
    pixel_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req > 0) begin
        pixel_ch.ready <= 1'b0;
        repeat (hold_off_req) @(posedge clk);
        hold_off_req = 0;
      end
      gap = idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        pixel_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pixel_ch.ready <= 1'b1;
      do @(posedge clk); while (!pixel_ch.valid && hold_off_req == 0);
    end
  end

  // This task lowers valid only before a gap, so back-to-back requests keep it high.
  task automatic offer_glyph_byte(input glyph_req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      glyph_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    glyph_ch.valid          <= 1'b1;
    glyph_ch.first_of_glyph <= r.first;
    glyph_ch.origin_y       <= r.oy;
    glyph_ch.origin_x       <= r.ox;
    glyph_ch.fg_color       <= r.fg;
    glyph_ch.bg_color       <= r.bg;
    glyph_ch.glyph_code     <= r.code;
    glyph_ch.font_byte      <= r.fbyte;
    do @(posedge clk); while (!glyph_ch.ready);
    items_sent++;
  endtask

  task automatic wait_for_pixels();
    glyph_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_font_geometry(input logic [7:0] w, input logic [7:0] h,
                                    input logic [7:0] fc);
    logic [CFG_IDX_W-1:0] idx[3];
    logic [CFG_DATA_W-1:0] val[3];
    int i;
    idx[0] = REG_GLYPH_WIDTH;
    idx[1] = REG_GLYPH_HEIGHT;
    idx[2] = REG_FIRST_CODE;
    val[0] = w;
    val[1] = h;
    val[2] = fc;
    wait_for_pixels();
    for (i = 0; i < 3; i++) begin
      cfg_ch.valid     <= 1'b1;
      cfg_ch.reg_index <= idx[i];
      cfg_ch.data      <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic glyph_req_t make_req(input logic first, input logic [CW-1:0] oy,
                                          input logic [CW-1:0] ox, input logic [7:0] fg,
                                          input logic [7:0] bg, input logic [7:0] code,
                                          input logic [7:0] fbyte);
    glyph_req_t r;
    r.first = first;
    r.oy    = oy;
    r.ox    = ox;
    r.fg    = fg;
    r.bg    = bg;
    r.code  = code;
    r.fbyte = fbyte;
    return r;
  endfunction

  function automatic glyph_req_t random_req(input logic first);
    glyph_req_t r;
    int pick;
    r = make_req(first, CW'($urandom), CW'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
    // Half the glyphs have a transparent background.
    if ($urandom_range(0, 1) == 0) r.bg = '0;
    pick = $urandom_range(0, 5);
    if (pick == 0) r.fbyte = 8'h00;
    else if (pick == 1) r.fbyte = 8'hFF;
    return r;
  endfunction

  task automatic send_glyph(input int nbytes);
    int i;
    for (i = 0; i < nbytes; i++) offer_glyph_byte(random_req(i == 0));
  endtask

  function automatic int glyph_length();
    return ((eff_width(m_width) + 7) / 8) * (m_height == 6'd0 ? 1 : m_height);
  endfunction

  task automatic test_before_first_glyph();
    offer_glyph_byte(make_req(1'b0, 12'h5A5, 12'hA5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    offer_glyph_byte(make_req(1'b0, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 8'h00));
    offer_glyph_byte(make_req(1'b0, 12'hFFF, 12'hFFF, 8'h12, 8'h34, 8'h56, 8'h81));
  endtask

  task automatic test_glyph_extremes();
    // Origin at the far corner, so x wraps; code below the first code wraps the offset.
    offer_glyph_byte(make_req(1'b1, 12'hFFF, 12'hFFF, 8'hFF, 8'h00, 8'h00, 8'hFF));
    offer_glyph_byte(make_req(1'b0, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 8'h00));
    offer_glyph_byte(make_req(1'b0, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 8'h55));
    // Opaque background with a foreground of zero.
    offer_glyph_byte(make_req(1'b1, 12'h000, 12'h000, 8'h00, 8'hFF, 8'hFF, 8'h00));
    offer_glyph_byte(make_req(1'b0, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 8'hFF));
    offer_glyph_byte(make_req(1'b1, 12'h800, 12'h7FF, 8'hA5, 8'h5A, 8'd32, 8'hAA));
  endtask

  task automatic test_width_extremes();
    // Zero width acts as one pixel; zero height pins every glyph at address zero.
    load_font_geometry(8'h00, 8'h00, 8'h00);
    offer_glyph_byte(make_req(1'b1, 12'h010, 12'h020, 8'h77, 8'h00, 8'h99, 8'h80));
    offer_glyph_byte(make_req(1'b0, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 8'h7F));
    // Width above the maximum is clamped; the code offset wraps to its largest value.
    load_font_geometry(8'hFF, 8'hFF, 8'hFF);
    offer_glyph_byte(make_req(1'b1, 12'h100, 12'hFF8, 8'h3C, 8'hC3, 8'hFE, 8'hF0));
    offer_glyph_byte(make_req(1'b0, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 8'h0F));
    offer_glyph_byte(make_req(1'b0, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 8'hFF));
    offer_glyph_byte(make_req(1'b0, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 8'h01));
    load_font_geometry(8'h45, 8'h43, 8'h41);
    offer_glyph_byte(make_req(1'b1, 12'h001, 12'h002, 8'h11, 8'h22, 8'h40, 8'hFF));
    offer_glyph_byte(make_req(1'b0, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 8'h07));
    load_font_geometry(8'd32, 8'd1, 8'd0);
    offer_glyph_byte(make_req(1'b1, 12'h3FF, 12'h400, 8'hEE, 8'h00, 8'hFF, 8'hC1));
  endtask

  task automatic test_width_change_mid_glyph();
    load_font_geometry(8'd32, 8'd2, 8'd32);
    offer_glyph_byte(make_req(1'b1, 12'h020, 12'h030, 8'h44, 8'h00, 8'd40, 8'hFF));
    offer_glyph_byte(make_req(1'b0, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 8'hF0));
    // The column count is already past the new width, so the row ends after one pixel.
    load_font_geometry(8'd3, 8'd2, 8'd32);
    offer_glyph_byte(make_req(1'b0, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 8'hFF));
    offer_glyph_byte(make_req(1'b0, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 8'hB6));
  endtask

  task automatic test_backpressure();
    int i;
    load_font_geometry(8'd8, 8'd2, 8'($urandom));
    idle_on = 1'b0;
    hold_off_req = 300;
    for (i = 0; i < 12; i++) send_glyph(2);
    wait_for_pixels();
    idle_on = 1'b1;
  endtask

  task automatic test_random_glyphs();
    logic [7:0] widths[8];
    logic [7:0] fc;
    int phase;
    int phase_end;
    int pick;
    widths = '{8'd1, 8'd8, 8'd5, 8'd32, 8'd63, 8'd0, 8'd12, 8'h00};
    widths[7] = 8'($urandom);
    for (phase = 0; phase < 8; phase++) begin
      pick = $urandom_range(0, 3);
      fc = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
      load_font_geometry(widths[phase], 8'($urandom_range(1, 4)), fc);
      idle_on = (phase % 3) != 2;
      phase_end = items_sent + RANDOM_ITEMS / 8;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 15) send_glyph(glyph_length());
        else if (pick < 18) send_glyph($urandom_range(1, glyph_length() + 2));
        else offer_glyph_byte(random_req(1'($urandom_range(0, 1))));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst                     <= 1'b1;
    glyph_ch.valid          <= 1'b0;
    glyph_ch.first_of_glyph <= 1'b0;
    glyph_ch.origin_y       <= '0;
    glyph_ch.origin_x       <= '0;
    glyph_ch.fg_color       <= '0;
    glyph_ch.bg_color       <= '0;
    glyph_ch.glyph_code     <= '0;
    glyph_ch.font_byte      <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.reg_index        <= REG_GLYPH_WIDTH;
    cfg_ch.data             <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_before_first_glyph();
    test_glyph_extremes();
    test_width_extremes();
    test_width_change_mid_glyph();
    test_backpressure();
    test_random_glyphs();

    wait_for_pixels();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### glyph_bitmap_expander.f
src/gbe_pkg.sv
src/gbe_in_if.sv
src/gbe_out_if.sv
src/gbe_cfg_if.sv
src/gbe_lane.sv
src/gbe_merge.sv
src/glyph_bitmap_expander.sv
src/gbe_checker.sv
tb/glyph_bitmap_expander_tb.sv
